/* sv/ahp_pkg.sv */
// ----------------------------------------------------------------------------
// ahp_pkg
// Item types and codes shared by the auto-ranging histogram block.
// ----------------------------------------------------------------------------
package ahp_pkg;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam int VALUE_W = 20;
    localparam int TOTAL_W = 13;

    // Q1.16 one
    localparam logic [16:0] FRAC_ONE = 17'h10000;

    typedef struct packed {
        logic               func;
        logic signed [15:0] sample_value;
        logic               last_sample;
        logic [16:0]        fraction;
    } in_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [TOTAL_W-1:0]        sample_total;
        logic                      empty_flag;
        logic                      overflow_flag;
    } out_item_t;

endpackage

/* sv/ahp_ram.sv */
// ----------------------------------------------------------------------------
// ahp_ram
// Simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module ahp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/ahp_div.sv */
// ----------------------------------------------------------------------------
// ahp_div
// Restoring divider, one quotient bit per cycle, DW-bit quotient.
// ----------------------------------------------------------------------------
module ahp_div #(
    parameter int DW = 32,
    parameter int VW = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          busy,
    output logic          done,
    output logic [DW-1:0] quotient
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] quo_reg;
    logic [VW-1:0] rem_reg;
    logic [VW-1:0] dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [VW:0]   trial;
    logic          fits;

    assign trial = {rem_reg, quo_reg[DW-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CW'(DW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, subtract when it fits
            if (fits)
            begin
                rem_reg <= VW'(trial - {1'b0, dvs_reg});
            end
            else
            begin
                rem_reg <= trial[VW-1:0];
            end
            quo_reg <= {quo_reg[DW-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* sv/auto_range_histogram_percentile.sv */
// ----------------------------------------------------------------------------
// auto_range_histogram_percentile
// Loads a sample set, bins it into buckets between its min and max, and
// answers percentile queries with a bucket midpoint, or the min or max at the edges.
// ----------------------------------------------------------------------------
//  channel  | signals                       | payload
//  input    | in_valid / in_ready           | ahp_pkg::in_item_t  in_data
//  output   | out_valid / out_ready         | ahp_pkg::out_item_t out_data
//
// Load items are accepted back to back. After the last sample the bucket
// memory is cleared, then each stored sample is read, offset, scaled and
// divided in the serial divider (DW = SAMPLE_BITS + clog2(NUM_BUCKETS+1) + 4)
// and counted into its bucket; the divider is skipped when all samples are
// equal. A query walks the bucket memory, one bucket a cycle, then forms the
// midpoint in S_Q_MUL (NUM_BUCKETS is a power of two) and loads the output
// register in S_Q_OUT; edge fractions and empty sets skip the walk. in_ready
// is low while binning or querying; a waiting result stalls only the next
// query's S_Q_OUT state. Reset leaves the histogram empty.
// ----------------------------------------------------------------------------
module auto_range_histogram_percentile #(
    parameter int NUM_BUCKETS = 256,
    parameter int MAX_SAMPLES = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ahp_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output ahp_pkg::out_item_t out_data
);

    localparam int SB = SAMPLE_BITS;
    localparam int SA = $clog2(MAX_SAMPLES);
    localparam int TW = $clog2(MAX_SAMPLES + 1);
    localparam int BA = $clog2(NUM_BUCKETS);
    localparam int NB = $clog2(NUM_BUCKETS + 1);
    localparam int DW = SB + NB + 4;
    localparam int VW = (SB > NB) ? SB : NB;
    localparam int XW = (SB + 6 > ahp_pkg::VALUE_W) ? SB + 6 : ahp_pkg::VALUE_W;
    localparam int CW = 17 + TW;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_CLR    = 12'b000000000010,
        S_B_RD   = 12'b000000000100,
        S_B_OFF  = 12'b000000001000,
        S_B_MUL  = 12'b000000010000,
        S_B_DIV  = 12'b000000100000,
        S_B_BRD  = 12'b000001000000,
        S_B_BWR  = 12'b000010000000,
        S_Q_CUT  = 12'b000100000000,
        S_Q_WALK = 12'b001000000000,
        S_Q_MUL  = 12'b010000000000,
        S_Q_OUT  = 12'b100000000000
    } state_t;

    state_t                   state_reg;
    logic [TW-1:0]            load_cnt_reg;
    logic                     dropped_reg;
    logic signed [SB-1:0]     run_lo_reg;
    logic signed [SB-1:0]     run_hi_reg;
    logic signed [SB-1:0]     rng_lo_reg;
    logic signed [SB-1:0]     rng_hi_reg;
    logic [TW-1:0]            total_reg;
    logic [TW-1:0]            sidx_reg;
    logic [BA-1:0]            cidx_reg;
    logic [BA-1:0]            bkt_reg;
    logic [SB-1:0]            off_reg;
    logic [16:0]              frac_reg;
    logic [TW-1:0]            cutoff_reg;
    logic [TW-1:0]            run_reg;
    logic signed [XW-1:0]     res_reg;
    logic                     out_valid_reg;
    ahp_pkg::out_item_t       out_reg;

    // sample handling
    logic signed [SB-1:0]     in_v;
    logic signed [SB-1:0]     base_lo;
    logic signed [SB-1:0]     base_hi;
    logic [SB-1:0]            run_span;
    logic [SB-1:0]            rng_span;
    logic                     in_acc;
    logic                     store_we;
    logic [SB-1:0]            store_rdata;
    logic signed [SB-1:0]     store_v;

    // bucket memory
    logic                     bram_we;
    logic [BA-1:0]            bram_waddr;
    logic [TW-1:0]            bram_wdata;
    logic [BA-1:0]            bram_raddr;
    logic [TW-1:0]            bram_rdata;
    logic [TW-1:0]            run_sum;

    // divider
    logic                     div_start;
    logic [DW-1:0]            div_dividend;
    logic [VW-1:0]            div_divisor;
    logic                     div_busy;
    logic                     div_done;
    logic [DW-1:0]            div_quo;

    logic signed [XW-1:0]     lo_x;
    logic signed [XW-1:0]     hi_x;
    logic [DW-1:0]            mid_prod;
    logic signed [XW-1:0]     mid_x;
    logic                     out_free;

    assign in_acc   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || out_ready;

    assign in_v     = signed'(SB'(unsigned'(in_data.sample_value)));
    assign base_lo  = (load_cnt_reg == '0) ? in_v : run_lo_reg;
    assign base_hi  = (load_cnt_reg == '0) ? in_v : run_hi_reg;
    assign run_span = SB'(run_hi_reg - run_lo_reg);
    assign rng_span = SB'(rng_hi_reg - rng_lo_reg);
    assign store_v  = signed'(store_rdata);

    assign store_we = in_acc && (in_data.func == ahp_pkg::FUNC_LOAD)
                      && (load_cnt_reg < TW'(MAX_SAMPLES));

    ahp_ram #(
        .WIDTH (SB),
        .DEPTH (MAX_SAMPLES)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (load_cnt_reg[SA-1:0]),
        .wdata (unsigned'(in_v)),
        .raddr (sidx_reg[SA-1:0]),
        .rdata (store_rdata)
    );

    assign run_sum = run_reg + bram_rdata;

    always_comb
    begin
        bram_we    = 1'b0;
        bram_waddr = cidx_reg;
        bram_wdata = '0;
        bram_raddr = bkt_reg;
        case (state_reg)
            S_CLR:
            begin
                bram_we = 1'b1;
            end
            S_B_BWR:
            begin
                bram_we    = 1'b1;
                bram_waddr = bkt_reg;
                bram_wdata = bram_rdata + 1'b1;
            end
            S_Q_CUT:
            begin
                bram_raddr = '0;
            end
            S_Q_WALK:
            begin
                bram_raddr = (cidx_reg == BA'(NUM_BUCKETS - 1)) ? '0 : cidx_reg + 1'b1;
            end
            default:
            begin
                bram_raddr = bkt_reg;
            end
        endcase
    end

    ahp_ram #(
        .WIDTH (TW),
        .DEPTH (NUM_BUCKETS)
    ) u_buckets (
        .clk   (clk),
        .we    (bram_we),
        .waddr (bram_waddr),
        .wdata (bram_wdata),
        .raddr (bram_raddr),
        .rdata (bram_rdata)
    );

    assign div_start    = (state_reg == S_B_MUL);
    assign div_dividend = DW'(off_reg) * DW'(NUM_BUCKETS);
    assign div_divisor  = VW'(run_span);

    ahp_div #(
        .DW (DW),
        .VW (VW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign lo_x     = XW'(rng_lo_reg) <<< 4;
    assign hi_x     = XW'(rng_hi_reg) <<< 4;
    // midpoint offset (2i+1) * span * 8 / NUM_BUCKETS
    assign mid_prod = (DW'({bkt_reg, 1'b1}) * DW'(rng_span)) << 3;
    assign mid_x    = lo_x + signed'(XW'(mid_prod >> BA));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            load_cnt_reg  <= '0;
            dropped_reg   <= 1'b0;
            run_lo_reg    <= '0;
            run_hi_reg    <= '0;
            rng_lo_reg    <= '0;
            rng_hi_reg    <= '0;
            total_reg     <= '0;
            sidx_reg      <= '0;
            cidx_reg      <= '0;
            bkt_reg       <= '0;
            run_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && (state_reg != S_Q_OUT))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc && (in_data.func == ahp_pkg::FUNC_LOAD))
                    begin
                        if (load_cnt_reg < TW'(MAX_SAMPLES))
                        begin
                            load_cnt_reg <= load_cnt_reg + 1'b1;
                            run_lo_reg   <= (in_v < base_lo) ? in_v : base_lo;
                            run_hi_reg   <= (in_v > base_hi) ? in_v : base_hi;
                            dropped_reg  <= (load_cnt_reg == '0) ? 1'b0 : dropped_reg;
                        end
                        else
                        begin
                            dropped_reg <= 1'b1;
                        end
                        if (in_data.last_sample)
                        begin
                            sidx_reg  <= '0;
                            cidx_reg  <= '0;
                            state_reg <= S_CLR;
                        end
                    end
                    else if (in_acc)
                    begin
                        if (total_reg == '0)
                        begin
                            res_reg   <= '0;
                            state_reg <= S_Q_OUT;
                        end
                        else if (in_data.fraction == '0)
                        begin
                            res_reg   <= lo_x;
                            state_reg <= S_Q_OUT;
                        end
                        else if (in_data.fraction >= ahp_pkg::FRAC_ONE)
                        begin
                            res_reg   <= hi_x;
                            state_reg <= S_Q_OUT;
                        end
                        else
                        begin
                            frac_reg  <= in_data.fraction;
                            state_reg <= S_Q_CUT;
                        end
                    end
                end
                S_CLR:
                begin
                    cidx_reg <= cidx_reg + 1'b1;
                    if (cidx_reg == BA'(NUM_BUCKETS - 1))
                    begin
                        state_reg <= S_B_RD;
                    end
                end
                S_B_RD:
                begin
                    state_reg <= S_B_OFF;
                end
                S_B_OFF:
                begin
                    off_reg <= SB'(store_v - run_lo_reg);
                    if (run_span == '0)
                    begin
                        bkt_reg   <= '0;
                        state_reg <= S_B_BRD;
                    end
                    else
                    begin
                        state_reg <= S_B_MUL;
                    end
                end
                S_B_MUL:
                begin
                    state_reg <= S_B_DIV;
                end
                S_B_DIV:
                begin
                    if (div_done)
                    begin
                        // clamp the top edge into the last bucket
                        if (div_quo > DW'(NUM_BUCKETS - 1))
                        begin
                            bkt_reg <= BA'(NUM_BUCKETS - 1);
                        end
                        else
                        begin
                            bkt_reg <= div_quo[BA-1:0];
                        end
                        state_reg <= S_B_BRD;
                    end
                end
                S_B_BRD:
                begin
                    state_reg <= S_B_BWR;
                end
                S_B_BWR:
                begin
                    sidx_reg <= sidx_reg + 1'b1;
                    if (sidx_reg == load_cnt_reg - 1'b1)
                    begin
                        rng_lo_reg   <= run_lo_reg;
                        rng_hi_reg   <= run_hi_reg;
                        total_reg    <= load_cnt_reg;
                        load_cnt_reg <= '0;
                        state_reg    <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_B_RD;
                    end
                end
                S_Q_CUT:
                begin
                    cutoff_reg <= TW'((CW'(frac_reg) * CW'(total_reg)) >> 16);
                    run_reg    <= '0;
                    cidx_reg   <= '0;
                    state_reg  <= S_Q_WALK;
                end
                S_Q_WALK:
                begin
                    run_reg <= run_sum;
                    if (run_sum > cutoff_reg)
                    begin
                        bkt_reg   <= cidx_reg;
                        state_reg <= S_Q_MUL;
                    end
                    else if (cidx_reg == BA'(NUM_BUCKETS - 1))
                    begin
                        res_reg   <= hi_x;
                        state_reg <= S_Q_OUT;
                    end
                    else
                    begin
                        cidx_reg <= cidx_reg + 1'b1;
                    end
                end
                S_Q_MUL:
                begin
                    res_reg   <= mid_x;
                    state_reg <= S_Q_OUT;
                end
                S_Q_OUT:
                begin
                    // hold until the output register is free
                    if (out_free)
                    begin
                        out_reg.value         <= res_reg[ahp_pkg::VALUE_W-1:0];
                        out_reg.sample_total  <= ahp_pkg::TOTAL_W'(total_reg);
                        out_reg.empty_flag    <= (total_reg == '0);
                        out_reg.overflow_flag <= dropped_reg;
                        out_valid_reg         <= 1'b1;
                        state_reg             <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTHESIS
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.empty_flag) |-> (out_data.value == '0
        && out_data.sample_total == '0))
        else $error("empty result carries data");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_data.func == ahp_pkg::FUNC_LOAD
        && in_data.last_sample) |=> (state_reg == S_CLR))
        else $error("last sample did not start bucket clear");
`endif

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for auto_range_histogram_percentile. Streams load and query items
// with random gaps and stalls on both sides. Predicts each query answer from
// its own copy of the sample store and buckets, and checks every result field.
// ----------------------------------------------------------------------------
module tb;

    localparam int NBKT     = 256;
    localparam int NSAMP    = 4096;
    localparam int WD_LIMIT = 400000;
    localparam int TAIL     = 400;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    ahp_pkg::in_item_t  in_data = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    ahp_pkg::out_item_t out_data;

    auto_range_histogram_percentile uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    int        store_mem [NSAMP];
    int        bkt_cnt [NBKT];
    int        rng_lo, rng_hi, hist_total, fill_cnt, run_lo, run_hi;
    bit        drop_seen;

    ahp_pkg::in_item_t  item_q [$];
    ahp_pkg::out_item_t answer_q [$];

    int        n_fail, n_loads, n_queries, n_sets, n_checked, idle_cyc;
    bit        in_took;
    int        in_gap, out_gap;
    bit        calm;

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, n_checked);
        n_fail++;
    endtask

    task automatic bin_samples();
        longint span;
        longint b;
        for (int i = 0; i < NBKT; i++)
            bkt_cnt[i] = 0;
        span = longint'(run_hi) - run_lo;
        for (int i = 0; i < fill_cnt; i++)
        begin
            b = 0;
            if (span != 0)
            begin
                b = (longint'(store_mem[i]) - run_lo) * NBKT / span;
                if (b > NBKT - 1)
                    b = NBKT - 1;
            end
            bkt_cnt[b]++;
        end
        hist_total = fill_cnt;
        rng_lo = run_lo;
        rng_hi = run_hi;
        fill_cnt = 0;
        n_sets++;
    endtask

    function automatic longint percentile(input int frac);
        longint cutoff;
        longint acc;
        longint span;
        if (frac == 0)
            return longint'(rng_lo) * 16;
        if (frac >= int'(ahp_pkg::FRAC_ONE))
            return longint'(rng_hi) * 16;
        cutoff = (longint'(frac) * hist_total) >> 16;
        span = longint'(rng_hi) - rng_lo;
        acc = 0;
        for (int i = 0; i < NBKT; i++)
        begin
            acc += bkt_cnt[i];
            if (acc > cutoff)
                return longint'(rng_lo) * 16 + ((2 * i + 1) * span * 8) / NBKT;
        end
        return longint'(rng_hi) * 16;
    endfunction

    task automatic absorb(input ahp_pkg::in_item_t it);
        int v;
        ahp_pkg::out_item_t r;
        if (it.func == ahp_pkg::FUNC_LOAD)
        begin
            v = it.sample_value;
            n_loads++;
            if (fill_cnt == 0)
            begin
                drop_seen = 1'b0;
                run_lo = v;
                run_hi = v;
            end
            if (fill_cnt < NSAMP)
            begin
                store_mem[fill_cnt] = v;
                fill_cnt++;
                if (v < run_lo)
                    run_lo = v;
                if (v > run_hi)
                    run_hi = v;
            end
            else
                drop_seen = 1'b1;
            if (it.last_sample)
                bin_samples();
        end
        else
        begin
            n_queries++;
            r = '0;
            r.empty_flag = (hist_total == 0);
            if (hist_total != 0)
                r.value = ahp_pkg::VALUE_W'(percentile(int'(it.fraction)));
            r.sample_total = ahp_pkg::TOTAL_W'(hist_total);
            r.overflow_flag = drop_seen;
            answer_q.push_back(r);
        end
    endtask

    function automatic ahp_pkg::in_item_t load_item(input int v, input bit last);
        ahp_pkg::in_item_t it;
        it.func = ahp_pkg::FUNC_LOAD;
        it.sample_value = 16'(v);
        it.last_sample = last;
        it.fraction = 17'($urandom);
        return it;
    endfunction

    function automatic ahp_pkg::in_item_t query_item(input int frac);
        ahp_pkg::in_item_t it;
        it.func = ahp_pkg::FUNC_QUERY;
        it.sample_value = 16'($urandom);
        it.last_sample = 1'($urandom);
        it.fraction = 17'(frac);
        return it;
    endfunction

    function automatic int pick_frac();
        int k;
        k = $urandom_range(0, 9);
        case (k)
            0: return 0;
            1: return int'(ahp_pkg::FRAC_ONE);
            2: return $urandom_range(int'(ahp_pkg::FRAC_ONE) + 1, 131071);
            3: return $urandom_range(1, 64);
            4: return $urandom_range(65472, 65535);
            default: return $urandom_range(1, 65535);
        endcase
    endfunction

    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 99);
        if (calm || k < 65)
            return 0;
        if (k < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // driver: present the next item once the current one is taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_took)
            begin
                if (in_gap > 0)
                begin
                    in_gap <= in_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (item_q.size() > 0)
                begin
                    in_data <= item_q.pop_front();
                    in_valid <= 1'b1;
                    in_gap <= pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
            if (out_gap > 0)
            begin
                out_gap <= out_gap - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                out_gap <= pick_gap();
            end
        end
    end

    // monitor: predict on accepted inputs, check accepted results
    always @(posedge clk)
    begin
        in_took <= in_valid && in_ready;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                absorb(in_data);
            if (out_valid && out_ready)
            begin
                n_checked++;
                if (answer_q.size() == 0)
                begin
                    report("stray result", out_data.value, 0);
                end
                else
                begin
                    ahp_pkg::out_item_t w;
                    w = answer_q.pop_front();
                    if (out_data.value !== w.value)
                        report("value", out_data.value, w.value);
                    if (out_data.sample_total !== w.sample_total)
                        report("sample_total", out_data.sample_total, w.sample_total);
                    if (out_data.empty_flag !== w.empty_flag)
                        report("empty_flag", out_data.empty_flag, w.empty_flag);
                    if (out_data.overflow_flag !== w.overflow_flag)
                        report("overflow_flag", out_data.overflow_flag, w.overflow_flag);
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cyc <= 0;
            else if (idle_cyc + 1 >= WD_LIMIT)
            begin
                $display("timeout with %0d results outstanding", answer_q.size());
                $display("[auto_range_histogram_percentile] ERROR");
                $finish;
            end
            else
                idle_cyc <= idle_cyc + 1;
        end
    end

    task automatic push_set(input int len, input int base, input int spread, input int qrate);
        int v;
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 99) < qrate)
                item_q.push_back(query_item(pick_frac()));
            v = base + $urandom_range(0, spread);
            if (v > 32767)
                v = 32767;
            item_q.push_back(load_item(v, i == len - 1));
        end
    endtask

    initial
    begin
        int pushed;
        int len;
        int base;
        int spread;
        int k;
        n_fail = 0; n_loads = 0; n_queries = 0; n_sets = 0; n_checked = 0;
        idle_cyc = 0; in_took = 0; in_gap = 0; out_gap = 0; calm = 0;
        rng_lo = 0; rng_hi = 0; hist_total = 0; fill_cnt = 0;
        run_lo = 0; run_hi = 0; drop_seen = 0;
        for (int i = 0; i < NBKT; i++)
            bkt_cnt[i] = 0;

        // empty histogram
        item_q.push_back(query_item(0));
        item_q.push_back(query_item(32768));
        item_q.push_back(query_item(int'(ahp_pkg::FRAC_ONE)));
        // one sample: all equal, bucket zero
        item_q.push_back(load_item(-32768, 1'b1));
        item_q.push_back(query_item(1));
        item_q.push_back(query_item(65535));
        item_q.push_back(query_item(131071));
        // full-scale extremes
        item_q.push_back(load_item(-32768, 1'b0));
        item_q.push_back(load_item(32767, 1'b0));
        item_q.push_back(query_item(40000));       // answered from previous set
        item_q.push_back(load_item(0, 1'b0));
        item_q.push_back(load_item(-1, 1'b1));
        item_q.push_back(query_item(0));
        item_q.push_back(query_item(16384));
        item_q.push_back(query_item(32768));
        item_q.push_back(query_item(65535));
        item_q.push_back(query_item(int'(ahp_pkg::FRAC_ONE)));
        // equal samples of a larger value
        for (int i = 0; i < 3; i++)
            item_q.push_back(load_item(32767, i == 2));
        item_q.push_back(query_item(30000));
        item_q.push_back(query_item(0));

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // hold the sender until every pending answer is back
        wait (item_q.size() == 0 && !in_valid && answer_q.size() == 0);

        pushed = 0;
        while (pushed < 900)
        begin
            if (pushed % 150 < 30)
                calm = 1'b1;
            else
                calm = 1'b0;
            k = $urandom_range(0, 19);
            if (k < 13)
                len = $urandom_range(1, 24);
            else if (k < 19)
                len = $urandom_range(25, 60);
            else
                len = $urandom_range(100, 200);
            k = $urandom_range(0, 3);
            case (k)
                0: begin base = $urandom_range(0, 65535) - 32768; spread = 0; end
                1: begin base = $urandom_range(0, 65000) - 32768; spread = $urandom_range(1, 300); end
                default: begin base = -32768; spread = 65535; end
            endcase
            push_set(len, base, spread, 15);
            for (int q = $urandom_range(1, 5); q > 0; q--)
                item_q.push_back(query_item(pick_frac()));
            pushed += len + 4;
            // stray query between sets
            if ($urandom_range(0, 9) == 0)
                item_q.push_back(query_item($urandom_range(0, 131071)));
            wait (item_q.size() < 64);
        end

        wait (item_q.size() == 0 && !in_valid && answer_q.size() == 0);
        repeat (TAIL) @(posedge clk);
        $display("covered %0d loads in %0d binned sets and %0d queries, %0d results checked",
                 n_loads, n_sets, n_queries, n_checked);
        $display("mismatches and stray results: %0d, answers left: %0d", n_fail, answer_q.size());
        if (n_fail == 0 && answer_q.size() == 0)
            $display("[auto_range_histogram_percentile] OK");
        else
            $display("[auto_range_histogram_percentile] ERROR");
        $finish;
    end
endmodule
